[hw/rtl/wilder_adx_indicator_assert.svh]
// assertion macros for the adx indicator checker
`ifndef WILDER_ADX_INDICATOR_ASSERT_SVH
`define WILDER_ADX_INDICATOR_ASSERT_SVH

// clocked assertion, off while reset is high
`define WADX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion, also checked through reset
`define WADX_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/wadx_pkg.sv]
// shared types and constants of the adx indicator
package wadx_pkg;

  localparam int PRICE_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int MAX_PERIOD = 64;
  localparam int PER_BITS   = 7;
  localparam int SUM_BITS   = 54;
  localparam int MOVE_BITS  = PRICE_BITS + FRAC_BITS;
  localparam int PCT_BITS   = 23;
  localparam int DIV_BITS   = SUM_BITS + 7 + FRAC_BITS;
  localparam int DCNT_BITS  = 7;
  localparam int HIST_AW    = 6;
  localparam int TOTAL_BITS = 29;
  localparam int PROD_BITS  = 2 * PCT_BITS;
  localparam int ADXP_BITS  = 31;

  localparam logic [PCT_BITS-1:0] PCT_MAX     = 23'd6553600;
  localparam logic [PER_BITS-1:0] PERIOD_RST  = 7'd14;
  localparam logic [PER_BITS-1:0] BARS_MAX    = 7'd127;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ACCUM,
    ST_LOAD,
    ST_WAIT,
    ST_DX_MUL,
    ST_FIRST,
    ST_ADX_MUL,
    ST_FINISH,
    ST_COMMIT,
    ST_OUTPUT
  } state_t;

  typedef enum logic [2:0] {
    OP_SMP,
    OP_SMM,
    OP_SMR,
    OP_DIP,
    OP_DIM,
    OP_DX,
    OP_AVG,
    OP_ADX
  } op_t;

  typedef struct packed {
    logic accept;
    logic moves;
    logic accum;
    logic div_go;
    logic capture;
    logic dx_mul;
    logic first;
    logic adx_mul;
    logic finish;
    logic commit;
    logic out_load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic fin;
    logic bars_zero;
    logic warm;
    logic adx_valid;
    logic avg_due;
    logic div_done;
    logic out_free;
  } stat_t;

endpackage

[hw/rtl/wadx_if.sv]
// bar and result channel interfaces
interface wadx_bar_if;
  logic                             valid;
  logic                             ready;
  logic [wadx_pkg::PRICE_BITS-1:0]  bar_high;
  logic [wadx_pkg::PRICE_BITS-1:0]  bar_low;
  logic [wadx_pkg::PRICE_BITS-1:0]  bar_close;
  logic                             bar_final;

  modport source (output valid, bar_high, bar_low, bar_close, bar_final, input ready);
  modport sink (input valid, bar_high, bar_low, bar_close, bar_final, output ready);
endinterface

interface wadx_res_if;
  logic                           valid;
  logic                           ready;
  logic [wadx_pkg::PCT_BITS-1:0]  adx_value;
  logic [wadx_pkg::PCT_BITS-1:0]  adxr_value;
  logic [wadx_pkg::PCT_BITS-1:0]  plus_di;
  logic [wadx_pkg::PCT_BITS-1:0]  minus_di;
  logic                           adx_ready;
  logic                           adxr_ready;

  modport source (output valid, adx_value, adxr_value, plus_di, minus_di, adx_ready,
                  adxr_ready, input ready);
  modport sink (input valid, adx_value, adxr_value, plus_di, minus_di, adx_ready,
                adxr_ready, output ready);
endinterface

[hw/rtl/wadx_div.sv]
// shared restoring divider, one quotient bit per cycle
module wadx_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [wadx_pkg::DIV_BITS-1:0] dividend,
  input  logic [wadx_pkg::SUM_BITS-1:0] divisor,
  output logic                          done,
  output logic [wadx_pkg::DIV_BITS-1:0] quotient
);
  import wadx_pkg::*;

  logic                 busy;
  logic [DCNT_BITS-1:0] cnt;
  logic [DIV_BITS-1:0]  quo;
  logic [SUM_BITS-1:0]  rem;
  logic [SUM_BITS-1:0]  den;
  logic [SUM_BITS:0]    trial;
  logic [SUM_BITS:0]    diff;
  logic                 fits;

  assign trial    = {rem, quo[DIV_BITS-1]};
  assign fits     = trial >= {1'b0, den};
  assign diff     = trial - {1'b0, den};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_BITS'(DIV_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo <= dividend;
      rem <= '0;
      den <= divisor;
    end else if (busy) begin
      rem <= fits ? diff[SUM_BITS-1:0] : trial[SUM_BITS-1:0];
      quo <= {quo[DIV_BITS-2:0], fits};
    end
  end

endmodule

[hw/rtl/wadx_dp.sv]
// datapath: bar registers, smoothed sums, adx state, history and output register
module wadx_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  wadx_pkg::cmd_t                cmd,
  output wadx_pkg::stat_t               st,
  input  logic                          cfg_we,
  input  logic [wadx_pkg::PER_BITS-1:0] cfg_data,
  wadx_bar_if.sink                      bars,
  wadx_res_if.source                    results
);
  import wadx_pkg::*;

  logic [PER_BITS-1:0]   period, p_eff;
  logic [PRICE_BITS-1:0] in_h, in_l, in_c;
  logic                  in_fin;
  logic [PRICE_BITS-1:0] last_high, last_low, last_close;
  logic [PER_BITS-1:0]   bars_seen;
  logic [SUM_BITS-1:0]   smooth_plus_dm, smooth_minus_dm, smooth_range;
  logic [SUM_BITS-1:0]   t_p, t_m, t_r;
  logic [MOVE_BITS-1:0]  mv_p, mv_m, mv_r;
  logic [PCT_BITS-1:0]   plus_di_reg, minus_di_reg, d_p, d_m;
  logic [PCT_BITS-1:0]   dx, adx_new, adx_reg, adxr_reg, prov_adxr, rd_data;
  logic [PER_BITS-1:0]   dx_count, history_count;
  logic [TOTAL_BITS-1:0] dx_total;
  logic                  adx_valid, adxr_valid, prov_rdy, adx_upd, adx_sm;
  logic [HIST_AW-1:0]    history_head, rd_addr;
  logic [PCT_BITS-1:0]   adx_history [MAX_PERIOD];
  logic [PROD_BITS-1:0]  dx_prod;
  logic [ADXP_BITS-1:0]  adx_prod;
  logic                  out_valid;

  logic [PRICE_BITS-1:0] up, dn, span, diff_h, diff_l, mx;
  logic [DIV_BITS-1:0]   div_a, div_q;
  logic [SUM_BITS-1:0]   div_b, sel_s, num_sel;
  logic [SUM_BITS+6:0]   num100;
  logic [SUM_BITS:0]     sm_sum, acc_p, acc_m, acc_r;
  logic [PCT_BITS-1:0]   pct_q, di_abs;
  logic [PCT_BITS:0]     di_sum, adxr_sum;
  logic                  div_done, hc_cond;
  logic [MOVE_BITS-1:0]  sel_mv;

  wadx_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quotient (div_q)
  );

  assign p_eff = (period < PER_BITS'(2)) ? PER_BITS'(2) :
                 (period > PER_BITS'(MAX_PERIOD)) ? PER_BITS'(MAX_PERIOD) : period;

  // directional moves and true range
  assign up     = (in_h > last_high) ? in_h - last_high : '0;
  assign dn     = (in_l < last_low) ? last_low - in_l : '0;
  assign span   = (in_h > in_l) ? in_h - in_l : '0;
  assign diff_h = (in_h > last_close) ? in_h - last_close : last_close - in_h;
  assign diff_l = (in_l > last_close) ? in_l - last_close : last_close - in_l;

  always_comb begin
    mx = span;
    if (diff_h > mx) mx = diff_h;
    if (diff_l > mx) mx = diff_l;
  end

  assign num_sel = (cmd.op == OP_DIP) ? t_p : t_m;
  assign num100  = (SUM_BITS+7)'(num_sel) * (SUM_BITS+7)'(100);
  assign di_sum  = {1'b0, d_p} + {1'b0, d_m};
  assign di_abs  = (d_p > d_m) ? d_p - d_m : d_m - d_p;
  assign pct_q   = (div_q >= DIV_BITS'(PCT_MAX)) ? PCT_MAX : div_q[PCT_BITS-1:0];
  assign rd_addr = history_head + HIST_AW'(1) - p_eff[HIST_AW-1:0];
  assign hc_cond = ({1'b0, history_count} + 8'd1) >= {1'b0, p_eff};
  assign adxr_sum = {1'b0, rd_data} + {1'b0, adx_new};

  always_comb begin
    div_a = '0;
    div_b = {{(SUM_BITS-PER_BITS){1'b0}}, p_eff};
    case (cmd.op)
      OP_SMP: div_a = DIV_BITS'(smooth_plus_dm);
      OP_SMM: div_a = DIV_BITS'(smooth_minus_dm);
      OP_SMR: div_a = DIV_BITS'(smooth_range);
      OP_DIP, OP_DIM: begin
        div_a = {num100, {FRAC_BITS{1'b0}}};
        div_b = t_r;
      end
      OP_DX: begin
        div_a = DIV_BITS'(dx_prod);
        div_b = SUM_BITS'(di_sum);
      end
      OP_AVG: begin
        div_a = DIV_BITS'(dx_total);
        div_b = SUM_BITS'(dx_count);
      end
      OP_ADX: div_a = DIV_BITS'(adx_prod);
      default: div_a = '0;
    endcase
  end

  // smoothing: s - s/p + x, saturated
  always_comb begin
    case (cmd.op)
      OP_SMM: begin
        sel_s  = smooth_minus_dm;
        sel_mv = mv_m;
      end
      OP_SMR: begin
        sel_s  = smooth_range;
        sel_mv = mv_r;
      end
      default: begin
        sel_s  = smooth_plus_dm;
        sel_mv = mv_p;
      end
    endcase
  end

  assign sm_sum = {1'b0, sel_s - div_q[SUM_BITS-1:0]} + (SUM_BITS+1)'(sel_mv);
  assign acc_p  = {1'b0, smooth_plus_dm} + (SUM_BITS+1)'(mv_p);
  assign acc_m  = {1'b0, smooth_minus_dm} + (SUM_BITS+1)'(mv_m);
  assign acc_r  = {1'b0, smooth_range} + (SUM_BITS+1)'(mv_r);

  assign st.fin       = in_fin;
  assign st.bars_zero = bars_seen == '0;
  assign st.warm      = bars_seen < p_eff;
  assign st.adx_valid = adx_valid;
  assign st.avg_due   = ({1'b0, dx_count} + 8'd1) >= {1'b0, p_eff};
  assign st.div_done  = div_done;
  assign st.out_free  = !out_valid || results.ready;

  assign bars.ready    = cmd.accept;
  assign results.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      period          <= PERIOD_RST;
      last_high       <= '0;
      last_low        <= '0;
      last_close      <= '0;
      bars_seen       <= '0;
      smooth_plus_dm  <= '0;
      smooth_minus_dm <= '0;
      smooth_range    <= '0;
      plus_di_reg     <= '0;
      minus_di_reg    <= '0;
      dx_count        <= '0;
      dx_total        <= '0;
      adx_reg         <= '0;
      adx_valid       <= 1'b0;
      history_count   <= '0;
      history_head    <= '0;
      adxr_reg        <= '0;
      adxr_valid      <= 1'b0;
      out_valid       <= 1'b0;
      adx_upd         <= 1'b0;
      adx_sm          <= 1'b0;
    end else begin
      if (cfg_we) period <= cfg_data;
      if (cmd.accept) begin
        adx_upd <= 1'b0;
        adx_sm  <= 1'b0;
      end
      if (cmd.capture && (cmd.op == OP_AVG || cmd.op == OP_ADX)) begin
        adx_upd <= 1'b1;
        adx_sm  <= cmd.op == OP_ADX;
      end
      if (cmd.accum) begin
        smooth_plus_dm  <= acc_p[SUM_BITS] ? '1 : acc_p[SUM_BITS-1:0];
        smooth_minus_dm <= acc_m[SUM_BITS] ? '1 : acc_m[SUM_BITS-1:0];
        smooth_range    <= acc_r[SUM_BITS] ? '1 : acc_r[SUM_BITS-1:0];
      end
      if (cmd.first) begin
        dx_total <= dx_total + TOTAL_BITS'(dx);
        dx_count <= dx_count + 1'b1;
      end
      if (cmd.finish && in_fin) begin
        smooth_plus_dm  <= t_p;
        smooth_minus_dm <= t_m;
        smooth_range    <= t_r;
        plus_di_reg     <= d_p;
        minus_di_reg    <= d_m;
        if (adx_upd) begin
          adx_reg      <= adx_new;
          adx_valid    <= 1'b1;
          history_head <= history_head + 1'b1;
          if (history_count < PER_BITS'(MAX_PERIOD)) history_count <= history_count + 1'b1;
          if (adx_sm && hc_cond) begin
            adxr_reg   <= adxr_sum[PCT_BITS:1];
            adxr_valid <= 1'b1;
          end
        end
      end
      if (cmd.commit && in_fin) begin
        last_high  <= in_h;
        last_low   <= in_l;
        last_close <= in_c;
        if (bars_seen < BARS_MAX) bars_seen <= bars_seen + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // history memory
  always_ff @(posedge clk) begin
    if (cmd.finish && in_fin && adx_upd) adx_history[history_head] <= adx_new;
    rd_data <= adx_history[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_h   <= bars.bar_high;
      in_l   <= bars.bar_low;
      in_c   <= bars.bar_close;
      in_fin <= bars.bar_final;
    end
    if (cmd.moves) begin
      mv_p <= (up > dn) ? {up, {FRAC_BITS{1'b0}}} : '0;
      mv_m <= (dn > up) ? {dn, {FRAC_BITS{1'b0}}} : '0;
      mv_r <= {mx, {FRAC_BITS{1'b0}}};
    end
    if (cmd.capture) begin
      case (cmd.op)
        OP_SMP: t_p <= sm_sum[SUM_BITS] ? '1 : sm_sum[SUM_BITS-1:0];
        OP_SMM: t_m <= sm_sum[SUM_BITS] ? '1 : sm_sum[SUM_BITS-1:0];
        OP_SMR: t_r <= sm_sum[SUM_BITS] ? '1 : sm_sum[SUM_BITS-1:0];
        OP_DIP: d_p <= (t_r == '0) ? '0 : pct_q;
        OP_DIM: d_m <= (t_r == '0) ? '0 : pct_q;
        OP_DX:  dx  <= (di_sum == '0) ? '0 : div_q[PCT_BITS-1:0];
        default: adx_new <= div_q[PCT_BITS-1:0];
      endcase
    end
    if (cmd.dx_mul) dx_prod <= PROD_BITS'(di_abs) * PROD_BITS'(PCT_MAX);
    if (cmd.adx_mul) begin
      adx_prod <= ADXP_BITS'(adx_reg) * ADXP_BITS'(p_eff - 1'b1) + ADXP_BITS'(dx);
    end
    if (cmd.finish && !in_fin) begin
      prov_rdy  <= adxr_valid && hc_cond;
      prov_adxr <= adxr_sum[PCT_BITS:1];
    end
    if (cmd.out_load) begin
      results.plus_di  <= plus_di_reg;
      results.minus_di <= minus_di_reg;
      if (in_fin) begin
        results.adx_value  <= adx_valid ? adx_reg : '0;
        results.adx_ready  <= adx_valid;
        results.adxr_value <= adxr_valid ? adxr_reg : '0;
        results.adxr_ready <= adxr_valid;
      end else if (adx_valid) begin
        results.adx_value  <= adx_new;
        results.adx_ready  <= 1'b1;
        results.adxr_value <= prov_rdy ? prov_adxr : '0;
        results.adxr_ready <= prov_rdy;
      end else begin
        results.adx_value  <= '0;
        results.adx_ready  <= 1'b0;
        results.adxr_value <= '0;
        results.adxr_ready <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/wadx_ctrl.sv]
// controller: sequences one bar through the datapath and the shared divider
module wadx_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  wadx_pkg::stat_t st,
  output wadx_pkg::cmd_t  cmd
);
  import wadx_pkg::*;

  state_t state, state_next;
  op_t    op, op_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_SMP;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  always_comb begin
    state_next = state;
    op_next    = op;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_CHECK;
      ST_CHECK: begin
        if ((st.fin && st.bars_zero) || (!st.fin && !st.adx_valid)) begin
          state_next = ST_COMMIT;
        end else if (st.fin && st.warm) begin
          state_next = ST_ACCUM;
        end else begin
          state_next = ST_LOAD;
          op_next    = OP_SMP;
        end
      end
      ST_ACCUM: state_next = ST_COMMIT;
      ST_LOAD:  state_next = ST_WAIT;
      ST_WAIT: begin
        if (st.div_done) begin
          state_next = ST_LOAD;
          unique case (op)
            OP_SMP: op_next = OP_SMM;
            OP_SMM: op_next = OP_SMR;
            OP_SMR: op_next = OP_DIP;
            OP_DIP: op_next = OP_DIM;
            OP_DIM: state_next = ST_DX_MUL;
            OP_DX:  state_next = (st.fin && !st.adx_valid) ? ST_FIRST : ST_ADX_MUL;
            default: state_next = ST_FINISH;
          endcase
        end
      end
      ST_DX_MUL: begin
        state_next = ST_LOAD;
        op_next    = OP_DX;
      end
      ST_FIRST: begin
        if (st.avg_due) begin
          state_next = ST_LOAD;
          op_next    = OP_AVG;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_ADX_MUL: begin
        state_next = ST_LOAD;
        op_next    = OP_ADX;
      end
      ST_FINISH: state_next = ST_COMMIT;
      ST_COMMIT: state_next = ST_OUTPUT;
      ST_OUTPUT: if (st.out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.op       = op;
    cmd.accept   = (state == ST_IDLE) && in_valid;
    cmd.moves    = state == ST_CHECK;
    cmd.accum    = state == ST_ACCUM;
    cmd.div_go   = state == ST_LOAD;
    cmd.capture  = (state == ST_WAIT) && st.div_done;
    cmd.dx_mul   = state == ST_DX_MUL;
    cmd.first    = state == ST_FIRST;
    cmd.adx_mul  = state == ST_ADX_MUL;
    cmd.finish   = state == ST_FINISH;
    cmd.commit   = state == ST_COMMIT;
    cmd.out_load = (state == ST_OUTPUT) && st.out_free;
  end

endmodule

[hw/rtl/wilder_adx_indicator.sv]
// top level of the adx indicator
// One bar is processed at a time. A first bar and a provisional bar before the first ADX
// go from the check straight to the commit, a committed bar in the warm-up phase through
// the accumulate state. A bar in the smoothing phase runs six or seven divisions through
// one shared restoring divider that yields one quotient bit per cycle. The result sits in
// an output register; the next bar is taken while it waits for its transfer, and that
// bar stalls in its last state until the register is free.
module wilder_adx_indicator (
  input  logic                          clk,
  input  logic                          rst,
  wadx_bar_if.sink                      bars,
  wadx_res_if.source                    results,
  input  logic                          cfg_we,
  input  logic [wadx_pkg::PER_BITS-1:0] cfg_data
);
  import wadx_pkg::*;

  cmd_t  cmd;
  stat_t st;

  wadx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (bars.valid),
    .st       (st),
    .cmd      (cmd)
  );

  wadx_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .st       (st),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .bars     (bars),
    .results  (results)
  );

endmodule

[hw/rtl/wadx_checker.sv]
// port checker of the adx indicator and its bind
`include "wilder_adx_indicator_assert.svh"

module wadx_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_ready,
  input logic [wadx_pkg::PCT_BITS-1:0] adx_value,
  input logic [wadx_pkg::PCT_BITS-1:0] adxr_value,
  input logic                          adx_ready,
  input logic                          adxr_ready
);

  `WADX_ASSERT(a_hold, res_valid && !res_ready |=> res_valid, "result dropped while stalled")
  `WADX_ASSERT_RST(a_rst, rst |=> !res_valid, "result valid after reset")
  `WADX_ASSERT(a_adx_zero, res_valid && !adx_ready |-> adx_value == '0, "adx not zero")
  `WADX_ASSERT(a_adxr_zero, res_valid && !adxr_ready |-> adxr_value == '0, "adxr not zero")
  `WADX_ASSERT(a_adxr_adx, res_valid && adxr_ready |-> adx_ready, "adxr without adx")

endmodule

bind wilder_adx_indicator wadx_checker u_chk (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (results.valid),
  .res_ready  (results.ready),
  .adx_value  (results.adx_value),
  .adxr_value (results.adxr_value),
  .adx_ready  (results.adx_ready),
  .adxr_ready (results.adxr_ready)
);
